[sv/sfcr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the stereo FIR convolution reverb.
// No dependencies; imported by the top level and by sfcr_mix.
package sfcr_pkg;

    // Default sizes
    localparam int SFCR_MAX_TAPS    = 1024;
    localparam int SFCR_SAMPLE_BITS = 16;
    localparam int SFCR_TAP_BITS    = 24;

    // Fixed field widths
    localparam int FUNC_BITS      = 2;
    localparam int TAP_INDEX_BITS = 10;
    localparam int NUM_TAPS_BITS  = 11;
    localparam int IR_CH_BITS     = 2;
    localparam int WET_MIX_BITS   = 17;
    localparam int OUT_GAIN_BITS  = 16;
    localparam int REG_IDX_BITS   = 3;

    // Item function codes
    localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_TAP    = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_BITS-1:0] REG_ENABLE   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_NUM_TAPS = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_IR_CH    = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_WET_MIX  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_OUT_GAIN = 3'd4;

    // Unity wet fraction in Q1.16
    localparam logic [WET_MIX_BITS-1:0] MIX_ONE = 17'h10000;

    // Mixer settings handed to each channel
    typedef struct packed {
        logic [WET_MIX_BITS-1:0]  wet_mix;
        logic [OUT_GAIN_BITS-1:0] out_gain;
    } t_mix_cfg;

endpackage

[sv/sfcr_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sfcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sfcr_mix.sv]
`timescale 1ns / 1ps
// Per-channel output stage: rounds the tap sum to wet, mixes dry and wet,
// applies the output gain and saturates. Depends on sfcr_pkg.
module sfcr_mix #(
    parameter int SAMPLE_BITS = sfcr_pkg::SFCR_SAMPLE_BITS,
    parameter int TAP_BITS    = sfcr_pkg::SFCR_TAP_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [63:0]            i_acc,
    input  logic signed [SAMPLE_BITS-1:0] i_dry,
    input  sfcr_pkg::t_mix_cfg            i_cfg,
    output logic                          o_done,
    output logic signed [SAMPLE_BITS-1:0] o_y
);
    import sfcr_pkg::*;

    localparam int WET_BITS = 46;
    localparam int PD_BITS  = SAMPLE_BITS + 18;
    localparam int M_BITS   = 30;
    localparam int G_BITS   = M_BITS + OUT_GAIN_BITS + 1;
    localparam logic signed [63:0] WET_LIM = 64'sd1 <<< 44;
    localparam logic signed [63:0] MIX_LIM = 64'sd1 <<< 28;
    localparam logic signed [63:0] Y_HI    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] Y_LO    = -(64'sd1 <<< (SAMPLE_BITS - 1));

    logic [4:0]                    r_vld;
    logic signed [WET_BITS-1:0]    r_wet;
    logic signed [SAMPLE_BITS-1:0] r_dry;
    logic signed [PD_BITS-1:0]     r_pd;
    logic signed [41:0]            r_pl;
    logic signed [40:0]            r_ph;
    logic signed [M_BITS-1:0]      r_m;
    logic signed [G_BITS-1:0]      r_g;
    logic signed [SAMPLE_BITS-1:0] r_y;

    logic signed [63:0]      w_wet_sh;
    logic signed [63:0]      w_wet_c;
    logic [WET_MIX_BITS-1:0] w_wm;
    logic [WET_MIX_BITS-1:0] w_dg;
    logic signed [63:0]      w_mixed;
    logic signed [63:0]      w_m_sh;
    logic signed [63:0]      w_m_c;
    logic signed [63:0]      w_y_sh;
    logic signed [63:0]      w_y_c;

    // Round the tap sum to Q.15 and clamp
    always_comb begin
        w_wet_sh = (i_acc + (64'sd1 <<< (TAP_BITS - 2))) >>> (TAP_BITS - 1);
        if (w_wet_sh > WET_LIM) begin
            w_wet_c = WET_LIM;
        end else if (w_wet_sh < -WET_LIM) begin
            w_wet_c = -WET_LIM;
        end else begin
            w_wet_c = w_wet_sh;
        end
    end

    // Clamp the wet fraction and form the dry fraction
    always_comb begin
        w_wm = (i_cfg.wet_mix > MIX_ONE) ? MIX_ONE : i_cfg.wet_mix;
        w_dg = MIX_ONE - w_wm;
    end

    // Sum the mix terms, round by 16 bits and clamp
    always_comb begin
        w_mixed = 64'(r_pd) + (64'(r_ph) <<< 23) + 64'(r_pl);
        w_m_sh  = (w_mixed + 64'sd32768) >>> 16;
        if (w_m_sh > MIX_LIM) begin
            w_m_c = MIX_LIM;
        end else if (w_m_sh < -MIX_LIM) begin
            w_m_c = -MIX_LIM;
        end else begin
            w_m_c = w_m_sh;
        end
    end

    // Round the gain product by 12 bits and saturate to the sample width
    always_comb begin
        w_y_sh = (64'(r_g) + 64'sd2048) >>> 12;
        if (w_y_sh > Y_HI) begin
            w_y_c = Y_HI;
        end else if (w_y_sh < Y_LO) begin
            w_y_c = Y_LO;
        end else begin
            w_y_c = w_y_sh;
        end
    end

    // Advance the stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    // Five registered stages; the wet word is split so each product stays narrow
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_wet <= WET_BITS'(w_wet_c);
            r_dry <= i_dry;
        end
        if (r_vld[0]) begin
            r_pd <= $signed(r_dry) * $signed({1'b0, w_dg});
            r_pl <= $signed({1'b0, r_wet[22:0]}) * $signed({1'b0, w_wm});
            r_ph <= $signed(r_wet[WET_BITS-1:23]) * $signed({1'b0, w_wm});
        end
        if (r_vld[1]) begin
            r_m <= M_BITS'(w_m_c);
        end
        if (r_vld[2]) begin
            r_g <= r_m * $signed({1'b0, i_cfg.out_gain});
        end
        if (r_vld[3]) begin
            r_y <= SAMPLE_BITS'(w_y_c);
        end
    end

    assign o_done = r_vld[4];
    assign o_y    = r_y;

endmodule

[sv/stereo_fir_convolution_reverb_top.sv]
`timescale 1ns / 1ps
// Top level of the stereo FIR convolution reverb: register port, history and
// tap memories, tap walk with one MAC per channel. Depends on sfcr_pkg,
// sfcr_ram and sfcr_mix.
//
// A stereo sample (func 0) with the reverb active is processed in order:
// one multiply-accumulate per channel walks min(num_taps, MAX_TAPS) taps
// at one tap per cycle, reading the tap memories and the shared history
// memory on their single read ports, then drains through the r_v1 and r_v2
// registers, then passes a five-stage mixing pipeline. In bypass the dry
// sample is loaded straight into the output register. Either way, a result
// also waits for the previous one to leave the output register. Tap writes
// and history clears give no result; a clear is instant, as a fill count
// marks which history entries hold written samples. A new item is taken
// while the previous result still waits at the output register.
module stereo_fir_convolution_reverb_top #(
    parameter int MAX_TAPS    = sfcr_pkg::SFCR_MAX_TAPS,
    parameter int SAMPLE_BITS = sfcr_pkg::SFCR_SAMPLE_BITS,
    parameter int TAP_BITS    = sfcr_pkg::SFCR_TAP_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [4:0]                              paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // Input items
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [sfcr_pkg::FUNC_BITS-1:0]          i_func,
    input  logic signed [SAMPLE_BITS-1:0]           i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]           i_right_sample,
    input  logic                                    i_tap_channel,
    input  logic [sfcr_pkg::TAP_INDEX_BITS-1:0]     i_tap_index,
    input  logic signed [TAP_BITS-1:0]              i_tap_value,
    // Result items
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_left_out,
    output logic signed [SAMPLE_BITS-1:0]           o_right_out
);
    import sfcr_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int PW = TAP_BITS + SAMPLE_BITS;
    localparam logic signed [63:0] ACC_LIM = 64'sd1 <<< 62;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_MIX, S_OUT} t_state;

    // Configuration registers
    logic                     r_enable;
    logic [NUM_TAPS_BITS-1:0] r_num_taps;
    logic [IR_CH_BITS-1:0]    r_ir_channels;
    logic [WET_MIX_BITS-1:0]  r_wet_mix;
    logic [OUT_GAIN_BITS-1:0] r_out_gain;

    // Control
    t_state          r_state;
    logic [AW-1:0]   r_ptr;
    logic [CW-1:0]   r_fill;
    logic [AW-1:0]   r_haddr;
    logic [AW-1:0]   r_k;
    logic [CW-1:0]   r_cnt;
    logic            r_bypass;
    logic            r_v1;
    logic            r_v2;
    logic            r_out_valid;

    // Datapath
    logic signed [SAMPLE_BITS-1:0] r_dl;
    logic signed [SAMPLE_BITS-1:0] r_dr;
    logic                          r_z1;
    logic signed [PW-1:0]          r_pl;
    logic signed [PW-1:0]          r_pr;
    logic signed [63:0]            r_acc_l;
    logic signed [63:0]            r_acc_r;
    logic signed [SAMPLE_BITS-1:0] r_left_out;
    logic signed [SAMPLE_BITS-1:0] r_right_out;

    logic                          w_cfg_wr;
    logic                          w_in_acc;
    logic                          w_active;
    logic                          w_hist_we;
    logic                          w_tap_ok;
    logic                          w_tapl_we;
    logic                          w_tapr_we;
    logic [AW-1:0]                 n_ptr;
    logic [CW-1:0]                 n_fill;
    logic [CW-1:0]                 n_cnt;
    logic [AW-1:0]                 n_haddr;
    logic [2*SAMPLE_BITS-1:0]      w_hist_rd;
    logic [TAP_BITS-1:0]           w_tapl_rd;
    logic [TAP_BITS-1:0]           w_tapr_rd;
    logic [TAP_BITS-1:0]           w_tap_rsel;
    logic                          w_mix_start;
    logic                          w_done_l;
    logic                          w_done_r;
    logic signed [SAMPLE_BITS-1:0] w_y_l;
    logic signed [SAMPLE_BITS-1:0] w_y_r;
    t_mix_cfg                      w_mix_cfg;
    logic                          w_load_out;

    function automatic logic signed [63:0] sat_acc(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > ACC_LIM) begin
            r = ACC_LIM;
        end else if (v < -ACC_LIM) begin
            r = -ACC_LIM;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Register port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_num_taps    <= '0;
            r_ir_channels <= IR_CH_BITS'(1);
            r_wet_mix     <= WET_MIX_BITS'(32768);
            r_out_gain    <= OUT_GAIN_BITS'(4096);
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_ENABLE:   r_enable      <= pwdata[0];
                REG_NUM_TAPS: r_num_taps    <= pwdata[NUM_TAPS_BITS-1:0];
                REG_IR_CH:    r_ir_channels <= pwdata[IR_CH_BITS-1:0];
                REG_WET_MIX:  r_wet_mix     <= pwdata[WET_MIX_BITS-1:0];
                REG_OUT_GAIN: r_out_gain    <= pwdata[OUT_GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ENABLE:   prdata = 32'(r_enable);
            REG_NUM_TAPS: prdata = 32'(r_num_taps);
            REG_IR_CH:    prdata = 32'(r_ir_channels);
            REG_WET_MIX:  prdata = 32'(r_wet_mix);
            REG_OUT_GAIN: prdata = 32'(r_out_gain);
            default:      prdata = '0;
        endcase
    end

    // Item decode
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_active   = r_enable && (r_num_taps != '0);
    assign w_hist_we  = w_in_acc && (i_func == FUNC_SAMPLE) && w_active;
    assign w_tap_ok   = 32'(i_tap_index) < MAX_TAPS;
    assign w_tapl_we  = w_in_acc && (i_func == FUNC_TAP) && !i_tap_channel && w_tap_ok;
    assign w_tapr_we  = w_in_acc && (i_func == FUNC_TAP) && i_tap_channel && w_tap_ok;

    // Next pointer, fill count, tap count and walk address
    always_comb begin
        n_ptr   = (r_ptr == AW'(MAX_TAPS - 1)) ? '0 : r_ptr + 1'b1;
        n_fill  = (r_fill == CW'(MAX_TAPS)) ? r_fill : r_fill + 1'b1;
        n_cnt   = (32'(r_num_taps) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(r_num_taps);
        n_haddr = (r_haddr == '0) ? AW'(MAX_TAPS - 1) : r_haddr - 1'b1;
    end

    // Memories: history holds both channels side by side
    sfcr_ram #(.WIDTH(2 * SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (r_ptr),
        .i_wdata ({i_right_sample, i_left_sample}),
        .i_raddr (r_haddr),
        .o_rdata (w_hist_rd)
    );

    sfcr_ram #(.WIDTH(TAP_BITS), .DEPTH(MAX_TAPS)) u_tap_l (
        .i_clk   (i_clk),
        .i_we    (w_tapl_we),
        .i_waddr (AW'(i_tap_index)),
        .i_wdata (i_tap_value),
        .i_raddr (r_k),
        .o_rdata (w_tapl_rd)
    );

    sfcr_ram #(.WIDTH(TAP_BITS), .DEPTH(MAX_TAPS)) u_tap_r (
        .i_clk   (i_clk),
        .i_we    (w_tapr_we),
        .i_waddr (AW'(i_tap_index)),
        .i_wdata (i_tap_value),
        .i_raddr (r_k),
        .o_rdata (w_tapr_rd)
    );

    // Right channel uses the left taps for a mono impulse response
    assign w_tap_rsel = (r_ir_channels >= IR_CH_BITS'(2)) ? w_tapr_rd : w_tapl_rd;

    // Multiply and accumulate; history slots never written since a clear read as zero
    always_ff @(posedge i_clk) begin
        r_z1 <= !(CW'(r_haddr) < r_fill);
        if (r_z1) begin
            r_pl <= '0;
            r_pr <= '0;
        end else begin
            r_pl <= $signed(w_tapl_rd) * $signed(w_hist_rd[SAMPLE_BITS-1:0]);
            r_pr <= $signed(w_tap_rsel) * $signed(w_hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
        if (w_in_acc) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_v2) begin
            r_acc_l <= sat_acc(r_acc_l + 64'(r_pl));
            r_acc_r <= sat_acc(r_acc_r + 64'(r_pr));
        end
    end

    // Mixing stages
    assign w_mix_start = (r_state == S_DRAIN) && !r_v1 && !r_v2;
    assign w_mix_cfg   = '{wet_mix: r_wet_mix, out_gain: r_out_gain};

    sfcr_mix #(.SAMPLE_BITS(SAMPLE_BITS), .TAP_BITS(TAP_BITS)) u_mix_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mix_start),
        .i_acc   (r_acc_l),
        .i_dry   (r_dl),
        .i_cfg   (w_mix_cfg),
        .o_done  (w_done_l),
        .o_y     (w_y_l)
    );

    sfcr_mix #(.SAMPLE_BITS(SAMPLE_BITS), .TAP_BITS(TAP_BITS)) u_mix_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mix_start),
        .i_acc   (r_acc_r),
        .i_dry   (r_dr),
        .i_cfg   (w_mix_cfg),
        .o_done  (w_done_r),
        .o_y     (w_y_r)
    );

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_MAC);
            r_v2 <= r_v1;
            // Hold the result until taken; raise valid when a new one loads
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_dl <= i_left_sample;
                        r_dr <= i_right_sample;
                        unique case (i_func)
                            FUNC_SAMPLE: begin
                                if (w_active) begin
                                    r_ptr    <= n_ptr;
                                    r_fill   <= n_fill;
                                    r_haddr  <= r_ptr;
                                    r_k      <= '0;
                                    r_cnt    <= n_cnt;
                                    r_bypass <= 1'b0;
                                    r_state  <= S_MAC;
                                end else begin
                                    r_bypass <= 1'b1;
                                    r_state  <= S_OUT;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_ptr  <= '0;
                                r_fill <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC: begin
                    r_k     <= r_k + 1'b1;
                    r_haddr <= n_haddr;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_mix_start) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    if (w_done_l && w_done_r) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_left_out  <= r_bypass ? r_dl : w_y_l;
                        r_right_out <= r_bypass ? r_dr : w_y_r;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    // A clear empties the history at once
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == FUNC_CLEAR)) |=> (r_ptr == '0) && (r_fill == '0))
        else $error("history clear did not reset pointer and fill count");

    // Both channel mixers finish together, and only while waiting for them
    a_mix_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_l || w_done_r) |-> (w_done_l && w_done_r && (r_state == S_MIX)))
        else $error("channel mixers out of step");

    // An active sample adds one written history slot until the memory is full
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hist_we && (r_fill != CW'(MAX_TAPS))) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count did not advance on a sample");

    // A bypassed sample leaves unchanged
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_bypass) |=> (o_left_out == $past(r_dl)) && (o_right_out == $past(r_dr)))
        else $error("bypass output differs from dry input");

endmodule

[dv/stereo_fir_convolution_reverb_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for stereo_fir_convolution_reverb_top: a directed table, then
// random phases under several register settings and idling patterns. Depends on sfcr_pkg.
module stereo_fir_convolution_reverb_top_tb;
    import sfcr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SHOW_LIMIT  = 20;
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [15:0]          left;
        logic [15:0]          right;
        logic                 ch;
        logic [9:0]           idx;
        logic [23:0]          val;
    } reverb_item_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
    } frame_t;

    typedef struct packed {
        row_kind_t    kind;
        reverb_item_t item;
        logic [2:0]   reg_idx;
        logic [31:0]  reg_val;
        logic         has_typed;
        frame_t       typed_fr;
    } dir_row_t;

    // Clock, reset and ports
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [FUNC_BITS-1:0] i_func = '0;
    logic signed [15:0] i_left_sample = '0;
    logic signed [15:0] i_right_sample = '0;
    logic i_tap_channel = 1'b0;
    logic [9:0] i_tap_index = '0;
    logic signed [23:0] i_tap_value = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [15:0] o_left_out;
    logic signed [15:0] o_right_out;

    // Register mirror, reset values
    logic        cfg_enable   = 1'b1;
    logic [10:0] cfg_num_taps = 11'd0;
    logic [1:0]  cfg_ir_ch    = 2'd1;
    logic [16:0] cfg_wet_mix  = 17'd32768;
    logic [15:0] cfg_out_gain = 16'd4096;

    // Filter state
    logic signed [15:0] left_hist  [0:1023];
    logic signed [15:0] right_hist [0:1023];
    logic [9:0]         hist_ptr = '0;
    logic signed [23:0] left_taps  [0:1023];
    logic signed [23:0] right_taps [0:1023];
    bit                 tap_written [0:1][0:1023];

    frame_t     expected_frames[$];
    dir_row_t   dir_table[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int mismatch_count = 0;
    int frames_checked = 0;
    int tap_writes = 0;
    int history_clears = 0;
    int cycle_count = 0;

    stereo_fir_convolution_reverb_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_left_sample (i_left_sample),
        .i_right_sample(i_right_sample),
        .i_tap_channel (i_tap_channel),
        .i_tap_index   (i_tap_index),
        .i_tap_value   (i_tap_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_left_out    (o_left_out),
        .o_right_out   (o_right_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d frames still pending", $time, expected_frames.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint round_sh(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic void clear_history();
        int k;
        for (k = 0; k < 1024; k++) begin
            left_hist[k]  = '0;
            right_hist[k] = '0;
        end
        hist_ptr = '0;
    endfunction

    // Convolve one channel over the history and mix it with the dry sample
    function automatic logic [15:0] convolve_mix(input logic [15:0] dry_bits,
                                                 input bit right_side);
        longint acc, wet, mixed, m, y, wm, dry;
        int n, k;
        logic [9:0] slot;
        logic signed [23:0] tap;
        logic signed [15:0] past;
        dry = longint'($signed(dry_bits));
        n   = (cfg_num_taps > 11'd1024) ? 1024 : int'(cfg_num_taps);
        wm  = (cfg_wet_mix > MIX_ONE) ? 65536 : longint'(cfg_wet_mix);
        acc = 0;
        for (k = 0; k < n; k++) begin
            slot = hist_ptr - k[9:0];
            tap  = (right_side && cfg_ir_ch >= 2'd2) ? right_taps[k] : left_taps[k];
            past = right_side ? right_hist[slot] : left_hist[slot];
            acc  = clamp(acc + longint'(tap) * longint'(past),
                         -(longint'(1) << 62), longint'(1) << 62);
        end
        wet   = clamp(round_sh(acc, 23), -(longint'(1) << 44), longint'(1) << 44);
        mixed = dry * (65536 - wm) + wet * wm;
        m     = clamp(round_sh(mixed, 16), -(longint'(1) << 28), longint'(1) << 28);
        y     = clamp(round_sh(m * longint'(cfg_out_gain), 12), -32768, 32767);
        return y[15:0];
    endfunction

    // Advance the filter state by one item; return 1 with the frame it yields
    function automatic bit reverb_predict(input reverb_item_t it, output frame_t fr);
        fr = '0;
        case (it.func)
            FUNC_TAP: begin
                tap_written[it.ch][it.idx] = 1'b1;
                if (it.ch)
                    right_taps[it.idx] = it.val;
                else
                    left_taps[it.idx] = it.val;
                return 1'b0;
            end
            FUNC_CLEAR: begin
                clear_history();
                return 1'b0;
            end
            FUNC_SAMPLE: begin
                if (!cfg_enable || cfg_num_taps == 11'd0) begin
                    fr.left  = it.left;
                    fr.right = it.right;
                    return 1'b1;
                end
                left_hist[hist_ptr]  = it.left;
                right_hist[hist_ptr] = it.right;
                fr.left  = convolve_mix(it.left, 1'b0);
                fr.right = convolve_mix(it.right, 1'b1);
                hist_ptr = hist_ptr + 10'd1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return 16'($urandom);
        if (pick < 8)
            return 16'($urandom_range(0, 4095) - 2048);
        case ($urandom_range(3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Taps shrink with index so long filters saturate only now and then
    function automatic logic [23:0] shaped_tap(input logic [9:0] idx);
        int mag, v;
        if ($urandom_range(9) == 0)
            return 24'($urandom);
        mag = 1 << (20 - int'(idx) / 128);
        v = int'($urandom_range(0, 2 * mag)) - mag;
        return 24'(v);
    endfunction

    function automatic reverb_item_t random_item();
        reverb_item_t it;
        int pick;
        it.left  = random_sample();
        it.right = random_sample();
        it.ch    = 1'($urandom_range(1));
        it.idx   = 10'($urandom_range(1023));
        it.val   = shaped_tap(it.idx);
        pick = $urandom_range(99);
        if (pick < 72)
            it.func = FUNC_SAMPLE;
        else if (pick < 90)
            it.func = FUNC_TAP;
        else if (pick < 94)
            it.func = FUNC_CLEAR;
        else
            it.func = FUNC_UNUSED;
        return it;
    endfunction

    function automatic dir_row_t sample_row(input logic [15:0] l, input logic [15:0] r,
                                            input logic has_typed, input logic [15:0] el,
                                            input logic [15:0] er);
        dir_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.func = FUNC_SAMPLE;
        row.item.left = l;
        row.item.right = r;
        row.has_typed = has_typed;
        row.typed_fr = {el, er};
        return row;
    endfunction

    function automatic dir_row_t tap_row(input logic ch, input logic [9:0] idx,
                                         input logic [23:0] val);
        dir_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.item.func = FUNC_TAP;
        row.item.ch = ch;
        row.item.idx = idx;
        row.item.val = val;
        return row;
    endfunction

    function automatic dir_row_t op_row(input logic [FUNC_BITS-1:0] func);
        dir_row_t row;
        row = '1;
        row.kind = ROW_ITEM;
        row.item.func = func;
        row.has_typed = 1'b0;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [31:0] value);
        dir_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = value;
        return row;
    endfunction

    // Check each accepted frame and stall the output at random
    always @(posedge i_clk) begin
        frame_t want;
        bit stall;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("%0t: frame with none expected: left %0d right %0d",
                             $time, o_left_out, o_right_out);
            end else begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (o_left_out !== want.left) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: left_out expected %0d, actual %0d",
                                 $time, $signed(want.left), o_left_out);
                end
                if (o_right_out !== want.right) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: right_out expected %0d, actual %0d",
                                 $time, $signed(want.right), o_right_out);
                end
            end
        end
        stall = (idle_mode == IDLE_RECV && $urandom_range(99) < 57) ||
                (idle_mode == IDLE_BOTH && $urandom_range(99) < 14);
        i_out_ready <= !stall;
    end

    // Offer one item, hold it until taken, then log what it should yield
    task automatic send_item(input reverb_item_t it, input logic use_typed,
                             input frame_t typed_fr);
        int gap;
        frame_t fr;
        gap = 0;
        if ((idle_mode == IDLE_SEND && $urandom_range(99) < 57) ||
            (idle_mode == IDLE_BOTH && $urandom_range(99) < 14))
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func         <= it.func;
        i_left_sample  <= it.left;
        i_right_sample <= it.right;
        i_tap_channel  <= it.ch;
        i_tap_index    <= it.idx;
        i_tap_value    <= it.val;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.func == FUNC_TAP)
            tap_writes++;
        if (it.func == FUNC_CLEAR)
            history_clears++;
        if (reverb_predict(it, fr))
            expected_frames.push_back(use_typed ? typed_fr : fr);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_frames.size() != 0);
    endtask

    // Drain, then give a trailing tap write or clear time to finish
    task automatic wait_settle();
        wait_drain();
        repeat (((cfg_num_taps > 11'd1024) ? 1024 : int'(cfg_num_taps)) + 16)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        wait_settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:   cfg_enable   = value[0];
            REG_NUM_TAPS: cfg_num_taps = value[10:0];
            REG_IR_CH:    cfg_ir_ch    = value[1:0];
            REG_WET_MIX:  cfg_wet_mix  = value[16:0];
            REG_OUT_GAIN: cfg_out_gain = value[15:0];
            default: ;
        endcase
    endtask

    // Write every tap the current length will read that is still unwritten
    task automatic load_taps(input int count, input bit both_sides);
        reverb_item_t it;
        int side, k;
        for (side = 0; side <= int'(both_sides); side++) begin
            for (k = 0; k < count; k++) begin
                if (!tap_written[side][k]) begin
                    it = random_item();
                    it.func = FUNC_TAP;
                    it.ch = side[0];
                    it.idx = k[9:0];
                    it.val = shaped_tap(k[9:0]);
                    send_item(it, 1'b0, '0);
                end
            end
        end
    endtask

    initial begin
        reverb_item_t it;
        logic        en;
        logic [10:0] nt;
        logic [1:0]  ir;
        logic [16:0] wm;
        logic [15:0] gn;
        int ph, counted, phase_items;
        bit paused;

        clear_history();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bypass after reset, extremes, saturation, zero gain, disable
        dir_table.push_back(sample_row(16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000));
        dir_table.push_back(sample_row(16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF));
        dir_table.push_back(sample_row(16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF));
        dir_table.push_back(op_row(FUNC_UNUSED));
        dir_table.push_back(tap_row(1'b0, 10'd0, 24'h7FFFFF));
        dir_table.push_back(tap_row(1'b1, 10'd0, 24'h800000));
        dir_table.push_back(tap_row(1'b0, 10'd1023, 24'h800000));
        dir_table.push_back(tap_row(1'b1, 10'd1023, 24'h7FFFFF));
        dir_table.push_back(cfg_row(REG_NUM_TAPS, 32'd1));
        dir_table.push_back(sample_row(16'h4000, 16'hC000, 1'b0, '0, '0));
        dir_table.push_back(sample_row(16'h1234, 16'hEDCC, 1'b0, '0, '0));
        dir_table.push_back(cfg_row(REG_WET_MIX, 32'(MIX_ONE)));
        dir_table.push_back(cfg_row(REG_OUT_GAIN, 32'd65535));
        dir_table.push_back(sample_row(16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h7FFF));
        dir_table.push_back(sample_row(16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h8000));
        dir_table.push_back(cfg_row(REG_IR_CH, 32'd2));
        dir_table.push_back(sample_row(16'h7FFF, 16'h7FFF, 1'b1, 16'h7FFF, 16'h8000));
        dir_table.push_back(op_row(FUNC_CLEAR));
        dir_table.push_back(sample_row(16'h8000, 16'h7FFF, 1'b0, '0, '0));
        dir_table.push_back(cfg_row(REG_OUT_GAIN, 32'd0));
        dir_table.push_back(sample_row(16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000));
        dir_table.push_back(cfg_row(REG_ENABLE, 32'd0));
        dir_table.push_back(sample_row(16'h0123, 16'hFEDC, 1'b1, 16'h0123, 16'hFEDC));
        dir_table.push_back(tap_row(1'b0, 10'd1, 24'h000001));

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG)
                write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
            else
                send_item(dir_table[i].item, dir_table[i].has_typed, dir_table[i].typed_fr);
        end

        // Random phases: each one sets every register, then streams items
        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    en = 1'b1; nt = 11'd8; ir = 2'd1; wm = 17'd32768; gn = 16'd4096;
                end
                1: begin
                    en = 1'b1; nt = 11'($urandom_range(1, 64)); ir = 2'd2;
                    wm = MIX_ONE; gn = 16'd4096;
                end
                2: begin
                    en = 1'b1; nt = 11'($urandom_range(1, 64)); ir = 2'd0;
                    wm = 17'd0; gn = 16'd65535;
                end
                3: begin
                    en = 1'b0; nt = 11'($urandom_range(1, 64)); ir = 2'd3;
                    wm = 17'($urandom_range(131071)); gn = 16'($urandom);
                end
                4: begin
                    en = 1'b1; nt = 11'd1024; ir = 2'd2;
                    wm = 17'($urandom_range(65536)); gn = 16'd4096;
                end
                5: begin
                    en = 1'b1; nt = 11'd2047; ir = 2'd1;
                    wm = 17'd131071; gn = 16'($urandom_range(1024, 8192));
                end
                6: begin
                    en = 1'b1; nt = 11'd0; ir = 2'd2;
                    wm = 17'($urandom_range(131071)); gn = 16'($urandom);
                end
                default: begin
                    en = ($urandom_range(7) != 0); nt = 11'($urandom_range(1, 48));
                    ir = 2'($urandom_range(3)); wm = 17'($urandom_range(131071));
                    gn = 16'($urandom_range(2048, 8192));
                end
            endcase
            idle_mode <= idle_mode_t'(ph % 4);
            write_reg(REG_ENABLE, 32'(en));
            write_reg(REG_NUM_TAPS, 32'(nt));
            write_reg(REG_IR_CH, 32'(ir));
            write_reg(REG_WET_MIX, 32'(wm));
            write_reg(REG_OUT_GAIN, 32'(gn));
            load_taps((nt > 11'd1024) ? 1024 : int'(nt), ir >= 2'd2);

            phase_items = (nt >= 11'd1024) ? 12 : 70;
            counted = 0;
            paused = 1'b0;
            while (counted < phase_items) begin
                // Hold off once mid-phase until the output has fully drained
                if (!paused && counted == phase_items / 2) begin
                    wait_drain();
                    paused = 1'b1;
                end
                it = random_item();
                send_item(it, 1'b0, '0);
                if (it.func != FUNC_UNUSED)
                    counted++;
            end
        end

        wait_settle();
        $display("Checked %0d frames over the directed table and 10 phases", frames_checked);
        $display("with %0d tap writes, %0d history clears, lengths from bypass to 1024 taps",
                 tap_writes, history_clears);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
